@@ rtl/core/pcvl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcvl_pkg: shared types and constants of the vertex lerp unit
// Holds the transaction side data and divider state carried between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package pcvl_pkg;

   // attribute layout
   localparam int ATTR_COMPONENTS_DEF = 4;
   localparam int ATTR_MAX            = 4;
   localparam int COMP_W              = 16;

   // perspective weight divider: quotient bits resolved per stage and stages
   localparam int STEP_BITS  = 4;
   localparam int DIV_STAGES = 8;

   localparam logic [16:0] ONE_T     = 17'd65536;
   localparam logic [24:0] DEPTH_MAX = 25'd16777216;

   // operands and finished linear results that ride along the divider
   typedef struct packed {
      logic        [31:0] wa;
      logic        [31:0] wb;
      logic signed [31:0] ua;
      logic signed [31:0] ub;
      logic signed [31:0] va;
      logic signed [31:0] vb;
      logic        [24:0] depth;
      logic        [63:0] attr;
   } side_type;

   // restoring divider state
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] den;
      logic [31:0] dvd;
      logic [31:0] quo;
   } div_type;

endpackage

`default_nettype wire

@@ rtl/core/pcvl_front.sv @@
// ----------------------------------------------------------------------------
// pcvl_front: operand conditioning and linear interpolation
// Clamps inputs, forms the perspective numerator and denominator, finishes
// the linear depth and attribute blends and seeds the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pcvl_front #(
   parameter int ATTR_COMPONENTS = pcvl_pkg::ATTR_COMPONENTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire logic [16:0]         weight_t,
   input  wire logic [24:0]         depth_a,
   input  wire logic [31:0]         clip_w_a,
   input  wire logic signed [31:0]  tex_u_a,
   input  wire logic signed [31:0]  tex_v_a,
   input  wire logic [63:0]         attrib_a,
   input  wire logic [24:0]         depth_b,
   input  wire logic [31:0]         clip_w_b,
   input  wire logic signed [31:0]  tex_u_b,
   input  wire logic signed [31:0]  tex_v_b,
   input  wire logic [63:0]         attrib_b,
   output logic                     out_valid,
   output pcvl_pkg::side_type       out_side,
   output pcvl_pkg::div_type        out_div
);

   localparam int AM = pcvl_pkg::ATTR_MAX;
   localparam int CW = pcvl_pkg::COMP_W;

   // ---------------- stage 1: clamp and differences ----------------
   logic [16:0]          t_in;
   logic [31:0]          wa_in, wb_in;
   logic [25:0]          dz;
   logic                 zneg_in;
   logic [24:0]          zmag_in;
   logic [AM-1:0]        aneg_in;
   logic [AM-1:0][CW-1:0] amag_in;

   logic                 s1_vld_ff;
   logic [16:0]          s1_t_ff;
   logic [31:0]          s1_wa_ff, s1_wb_ff;
   logic signed [31:0]   s1_ua_ff, s1_ub_ff, s1_va_ff, s1_vb_ff;
   logic [24:0]          s1_zb_ff, s1_zmag_ff;
   logic                 s1_zneg_ff;
   logic [63:0]          s1_ab_ff;
   logic [AM-1:0]        s1_aneg_ff;
   logic [AM-1:0][CW-1:0] s1_amag_ff;

   // clamp weight and zero w, split differences into sign and magnitude
   always_comb begin
      logic [CW:0] ad;
      t_in    = (weight_t > pcvl_pkg::ONE_T) ? pcvl_pkg::ONE_T : weight_t;
      wa_in   = (clip_w_a == '0) ? 32'd1 : clip_w_a;
      wb_in   = (clip_w_b == '0) ? 32'd1 : clip_w_b;
      dz      = {1'b0, depth_a} - {1'b0, depth_b};
      zneg_in = dz[25];
      zmag_in = zneg_in ? 25'(-dz) : dz[24:0];
      for (int c = 0; c < AM; c++) begin
         ad = {attrib_a[c*CW+CW-1], attrib_a[c*CW +: CW]}
            - {attrib_b[c*CW+CW-1], attrib_b[c*CW +: CW]};
         aneg_in[c] = ad[CW];
         amag_in[c] = ad[CW] ? CW'(-ad) : ad[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_t_ff    <= t_in;
         s1_wa_ff   <= wa_in;
         s1_wb_ff   <= wb_in;
         s1_ua_ff   <= tex_u_a;
         s1_ub_ff   <= tex_u_b;
         s1_va_ff   <= tex_v_a;
         s1_vb_ff   <= tex_v_b;
         s1_zb_ff   <= depth_b;
         s1_zmag_ff <= zmag_in;
         s1_zneg_ff <= zneg_in;
         s1_ab_ff   <= attrib_b;
         s1_aneg_ff <= aneg_in;
         s1_amag_ff <= amag_in;
      end
   end

   // ---------------- stage 2: products ----------------
   logic [16:0]          omt;
   logic [47:0]          num_in, pa_in;
   logic [41:0]          zprod_in;
   logic [AM-1:0][32:0]  aprod_in;

   logic                 s2_vld_ff;
   logic [47:0]          s2_num_ff, s2_pa_ff;
   logic [41:0]          s2_zprod_ff;
   logic [AM-1:0][32:0]  s2_aprod_ff;
   logic [31:0]          s2_wa_ff, s2_wb_ff;
   logic signed [31:0]   s2_ua_ff, s2_ub_ff, s2_va_ff, s2_vb_ff;
   logic [24:0]          s2_zb_ff;
   logic                 s2_zneg_ff;
   logic [63:0]          s2_ab_ff;
   logic [AM-1:0]        s2_aneg_ff;

   // weight the two w values and the linear differences
   always_comb begin
      omt      = pcvl_pkg::ONE_T - s1_t_ff;
      num_in   = {31'b0, s1_t_ff} * {16'b0, s1_wb_ff};
      pa_in    = {31'b0, omt} * {16'b0, s1_wa_ff};
      zprod_in = {25'b0, s1_t_ff} * {17'b0, s1_zmag_ff};
      for (int c = 0; c < AM; c++) begin
         aprod_in[c] = {16'b0, s1_t_ff} * {17'b0, s1_amag_ff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_num_ff   <= num_in;
         s2_pa_ff    <= pa_in;
         s2_zprod_ff <= zprod_in;
         s2_aprod_ff <= aprod_in;
         s2_wa_ff    <= s1_wa_ff;
         s2_wb_ff    <= s1_wb_ff;
         s2_ua_ff    <= s1_ua_ff;
         s2_ub_ff    <= s1_ub_ff;
         s2_va_ff    <= s1_va_ff;
         s2_vb_ff    <= s1_vb_ff;
         s2_zb_ff    <= s1_zb_ff;
         s2_zneg_ff  <= s1_zneg_ff;
         s2_ab_ff    <= s1_ab_ff;
         s2_aneg_ff  <= s1_aneg_ff;
      end
   end

   // ---------------- stage 3: denominator and linear results ----------------
   logic [47:0]          den_in;
   logic [25:0]          zq;
   logic [26:0]          zs;
   logic [24:0]          depth_in;
   logic [63:0]          attr_in;

   logic                 s3_vld_ff;
   logic [47:0]          s3_num_ff, s3_den_ff;
   pcvl_pkg::side_type   s3_side_ff;

   // round the linear offsets half up and apply them to vertex B
   always_comb begin
      logic [41:0] zr;
      logic [32:0] ar;
      logic [CW-1:0] aq, ab;
      den_in = s2_num_ff + s2_pa_ff;
      zr     = s2_zprod_ff + 42'd32768;
      zq     = zr[41:16];
      zs     = s2_zneg_ff ? ({2'b0, s2_zb_ff} - {1'b0, zq})
                          : ({2'b0, s2_zb_ff} + {1'b0, zq});
      if (zs[26]) begin
         depth_in = '0;
      end else if (zs > {2'b0, pcvl_pkg::DEPTH_MAX}) begin
         depth_in = pcvl_pkg::DEPTH_MAX;
      end else begin
         depth_in = zs[24:0];
      end
      attr_in = '0;
      for (int c = 0; c < AM; c++) begin
         ar = s2_aprod_ff[c] + 33'd32768;
         aq = ar[16+CW-1:16];
         ab = s2_ab_ff[c*CW +: CW];
         if (c < ATTR_COMPONENTS) begin
            attr_in[c*CW +: CW] = s2_aneg_ff[c] ? (ab - aq) : (ab + aq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_num_ff        <= s2_num_ff;
         s3_den_ff        <= den_in;
         s3_side_ff.wa    <= s2_wa_ff;
         s3_side_ff.wb    <= s2_wb_ff;
         s3_side_ff.ua    <= s2_ua_ff;
         s3_side_ff.ub    <= s2_ub_ff;
         s3_side_ff.va    <= s2_va_ff;
         s3_side_ff.vb    <= s2_vb_ff;
         s3_side_ff.depth <= depth_in;
         s3_side_ff.attr  <= attr_in;
      end
   end

   // ---------------- stage 4: normalize and seed divider ----------------
   logic [4:0]           sh;
   logic [31:0]          den_n, num_n;
   logic [63:0]          dividend;
   pcvl_pkg::div_type    div_in;

   logic                 s4_vld_ff;
   pcvl_pkg::side_type   s4_side_ff;
   pcvl_pkg::div_type    s4_div_ff;

   // shift both operands until the denominator fits in 32 bits
   always_comb begin
      sh = '0;
      for (int i = 0; i < 16; i++) begin
         if (s3_den_ff[32+i]) begin
            sh = 5'(i + 1);
         end
      end
      den_n      = 32'(s3_den_ff >> sh);
      num_n      = 32'(s3_num_ff >> sh);
      dividend   = {2'b0, num_n, 30'b0} + {33'b0, den_n[31:1]};
      div_in.rem = dividend[63:32];
      div_in.dvd = dividend[31:0];
      div_in.den = den_n;
      div_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff <= s3_side_ff;
         s4_div_ff  <= div_in;
      end
   end

   assign out_valid = s4_vld_ff;
   assign out_side  = s4_side_ff;
   assign out_div   = s4_div_ff;

endmodule

`default_nettype wire

@@ rtl/core/pcvl_div_step.sv @@
// ----------------------------------------------------------------------------
// pcvl_div_step: one stage of the perspective weight divider
// Resolves four quotient bits by restoring division and carries side data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcvl_div_step (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire pcvl_pkg::side_type  in_side,
   input  wire pcvl_pkg::div_type   in_div,
   output logic                     out_valid,
   output pcvl_pkg::side_type       out_side,
   output pcvl_pkg::div_type        out_div
);

   pcvl_pkg::div_type  div_in;
   logic               vld_ff;
   pcvl_pkg::side_type side_ff;
   pcvl_pkg::div_type  div_ff;

   // shift in one dividend bit at a time, subtract when it fits; repeat for STEP_BITS bits
   always_comb begin
      logic [32:0] r;
      div_in = in_div;
      for (int i = 0; i < pcvl_pkg::STEP_BITS; i++) begin
         r          = {div_in.rem, div_in.dvd[31]};
         div_in.dvd = {div_in.dvd[30:0], 1'b0};
         if (r >= {1'b0, div_in.den}) begin
            div_in.rem = 32'(r - {1'b0, div_in.den});
            div_in.quo = {div_in.quo[30:0], 1'b1};
         end else begin
            div_in.rem = r[31:0];
            div_in.quo = {div_in.quo[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= in_side;
         div_ff  <= div_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_side  = side_ff;
   assign out_div   = div_ff;

endmodule

`default_nettype wire

@@ rtl/core/pcvl_back.sv @@
// ----------------------------------------------------------------------------
// pcvl_back: perspective blends and output register
// Applies the Q1.30 perspective weight to w, u and v and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pcvl_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire pcvl_pkg::side_type  in_side,
   input  wire pcvl_pkg::div_type   in_div,
   output logic                     out_valid,
   output logic [24:0]              depth_out,
   output logic [31:0]              clip_w_out,
   output logic signed [31:0]       tex_u_out,
   output logic signed [31:0]       tex_v_out,
   output logic [63:0]              attrib_out
);

   // ---------------- stage 1: offset magnitudes times weight ----------------
   logic [30:0] s;
   logic        wneg_in, uneg_in, vneg_in;
   logic [62:0] wprod_in;
   logic [63:0] uprod_in, vprod_in;

   logic        b1_vld_ff;
   logic        b1_wneg_ff, b1_uneg_ff, b1_vneg_ff;
   logic [62:0] b1_wprod_ff;
   logic [63:0] b1_uprod_ff, b1_vprod_ff;
   logic [31:0] b1_wb_ff, b1_ub_ff, b1_vb_ff;
   logic [24:0] b1_depth_ff;
   logic [63:0] b1_attr_ff;

   // split each difference into sign and magnitude, then scale
   always_comb begin
      logic [32:0] dw, du, dv;
      logic [31:0] wmag;
      logic [32:0] umag, vmag;
      s        = in_div.quo[30:0];
      dw       = {1'b0, in_side.wa} - {1'b0, in_side.wb};
      du       = {in_side.ua[31], in_side.ua} - {in_side.ub[31], in_side.ub};
      dv       = {in_side.va[31], in_side.va} - {in_side.vb[31], in_side.vb};
      wneg_in  = dw[32];
      uneg_in  = du[32];
      vneg_in  = dv[32];
      wmag     = dw[32] ? 32'(-dw) : dw[31:0];
      umag     = du[32] ? (-du) : du;
      vmag     = dv[32] ? (-dv) : dv;
      wprod_in = {31'b0, wmag} * {32'b0, s};
      uprod_in = {31'b0, umag} * {33'b0, s};
      vprod_in = {31'b0, vmag} * {33'b0, s};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
      end else if (adv) begin
         b1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_wneg_ff  <= wneg_in;
         b1_uneg_ff  <= uneg_in;
         b1_vneg_ff  <= vneg_in;
         b1_wprod_ff <= wprod_in;
         b1_uprod_ff <= uprod_in;
         b1_vprod_ff <= vprod_in;
         b1_wb_ff    <= in_side.wb;
         b1_ub_ff    <= in_side.ub;
         b1_vb_ff    <= in_side.vb;
         b1_depth_ff <= in_side.depth;
         b1_attr_ff  <= in_side.attr;
      end
   end

   // ---------------- stage 2: round and apply to vertex B ----------------
   logic [31:0] w_in, u_in, v_in;

   always_comb begin
      logic [62:0] wr;
      logic [63:0] ur, vr;
      wr   = b1_wprod_ff + 63'h2000_0000;
      ur   = b1_uprod_ff + 64'h2000_0000;
      vr   = b1_vprod_ff + 64'h2000_0000;
      w_in = b1_wneg_ff ? (b1_wb_ff - wr[61:30]) : (b1_wb_ff + wr[61:30]);
      u_in = b1_uneg_ff ? (b1_ub_ff - ur[61:30]) : (b1_ub_ff + ur[61:30]);
      v_in = b1_vneg_ff ? (b1_vb_ff - vr[61:30]) : (b1_vb_ff + vr[61:30]);
   end

   logic        b2_vld_ff;
   logic [24:0] b2_depth_ff;
   logic [31:0] b2_w_ff, b2_u_ff, b2_v_ff;
   logic [63:0] b2_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_vld_ff <= 1'b0;
      end else if (adv) begin
         b2_vld_ff <= b1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b2_depth_ff <= b1_depth_ff;
         b2_w_ff     <= w_in;
         b2_u_ff     <= u_in;
         b2_v_ff     <= v_in;
         b2_attr_ff  <= b1_attr_ff;
      end
   end

   assign out_valid  = b2_vld_ff;
   assign depth_out  = b2_depth_ff;
   assign clip_w_out = b2_w_ff;
   assign tex_u_out  = signed'(b2_u_ff);
   assign tex_v_out  = signed'(b2_v_ff);
   assign attrib_out = b2_attr_ff;

endmodule

`default_nettype wire

@@ rtl/core/perspective_correct_vertex_lerp_unit.sv @@
// ----------------------------------------------------------------------------
// perspective_correct_vertex_lerp_unit: vertex interpolation between A and B
// Linear depth and attributes, perspective-correct w, u and v.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries two vertices and a weight t (65536 picks A,
//   0 picks B). A transaction is taken at a clock edge with req_valid high
//   and req_stall low. The rsp_ channel returns one interpolated vertex per
//   request, in order, under the same valid/stall rule.
//   From acceptance to rsp_valid a transaction passes four front stages
//   (clamp, products, linear results, normalize), eight divider stages
//   resolving four bits of the perspective weight each, and two blend
//   stages, the last being the output register. Throughput is one
//   transaction per cycle while the receiver does not stall a result.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   req_stall rises; nothing is dropped or repeated. Empty stages do not
//   advance independently, so bubbles stay in place during a stall.
//   Reset clears every stage valid bit; no request is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_correct_vertex_lerp_unit #(
   parameter int ATTR_COMPONENTS = pcvl_pkg::ATTR_COMPONENTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [16:0]         req_weight_t,
   input  wire logic [24:0]         req_depth_a,
   input  wire logic [31:0]         req_clip_w_a,
   input  wire logic signed [31:0]  req_tex_u_a,
   input  wire logic signed [31:0]  req_tex_v_a,
   input  wire logic [63:0]         req_attrib_a,
   input  wire logic [24:0]         req_depth_b,
   input  wire logic [31:0]         req_clip_w_b,
   input  wire logic signed [31:0]  req_tex_u_b,
   input  wire logic signed [31:0]  req_tex_v_b,
   input  wire logic [63:0]         req_attrib_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [24:0]              rsp_depth_out,
   output logic [31:0]              rsp_clip_w_out,
   output logic signed [31:0]       rsp_tex_u_out,
   output logic signed [31:0]       rsp_tex_v_out,
   output logic [63:0]              rsp_attrib_out
);

   localparam int NS = pcvl_pkg::DIV_STAGES;

   logic adv;

   logic                            vld [NS+1];
   pcvl_pkg::side_type              side [NS+1];
   pcvl_pkg::div_type               dv [NS+1];

   // advance everything unless a finished result is held back
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   pcvl_front #(
      .ATTR_COMPONENTS (ATTR_COMPONENTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .weight_t  (req_weight_t),
      .depth_a   (req_depth_a),
      .clip_w_a  (req_clip_w_a),
      .tex_u_a   (req_tex_u_a),
      .tex_v_a   (req_tex_v_a),
      .attrib_a  (req_attrib_a),
      .depth_b   (req_depth_b),
      .clip_w_b  (req_clip_w_b),
      .tex_u_b   (req_tex_u_b),
      .tex_v_b   (req_tex_v_b),
      .attrib_b  (req_attrib_b),
      .out_valid (vld[0]),
      .out_side  (side[0]),
      .out_div   (dv[0])
   );

   // chain of divider stages
   for (genvar g = 0; g < NS; g++) begin : g_div
      pcvl_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (vld[g]),
         .in_side   (side[g]),
         .in_div    (dv[g]),
         .out_valid (vld[g+1]),
         .out_side  (side[g+1]),
         .out_div   (dv[g+1])
      );
   end

   pcvl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (vld[NS]),
      .in_side    (side[NS]),
      .in_div     (dv[NS]),
      .out_valid  (rsp_valid),
      .depth_out  (rsp_depth_out),
      .clip_w_out (rsp_clip_w_out),
      .tex_u_out  (rsp_tex_u_out),
      .tex_v_out  (rsp_tex_v_out),
      .attrib_out (rsp_attrib_out)
   );

endmodule

`default_nettype wire

@@ rtl/core/pcvl_checker.sv @@
// ----------------------------------------------------------------------------
// pcvl_checker: port-level checks for the vertex lerp unit
// Watches the handshake and result ranges; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcvl_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [16:0]         req_weight_t,
   input  wire logic [24:0]         req_depth_a,
   input  wire logic [31:0]         req_clip_w_a,
   input  wire logic signed [31:0]  req_tex_u_a,
   input  wire logic signed [31:0]  req_tex_v_a,
   input  wire logic [63:0]         req_attrib_a,
   input  wire logic [24:0]         req_depth_b,
   input  wire logic [31:0]         req_clip_w_b,
   input  wire logic signed [31:0]  req_tex_u_b,
   input  wire logic signed [31:0]  req_tex_v_b,
   input  wire logic [63:0]         req_attrib_b,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [24:0]         rsp_depth_out,
   input  wire logic [31:0]         rsp_clip_w_out,
   input  wire logic signed [31:0]  rsp_tex_u_out,
   input  wire logic signed [31:0]  rsp_tex_v_out,
   input  wire logic [63:0]         rsp_attrib_out
);

   // hold a stalled result: it stays valid and clip w and tex u do not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_clip_w_out)
                                    && $stable(rsp_tex_u_out)))
      else $error("stalled result transaction changed");

   // drop all transactions at reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // back-pressure only comes from a held result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without result back-pressure");

   // interpolated w is positive and depth stays in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_clip_w_out != 32'd0)
                     && (rsp_depth_out <= 25'd16777216)))
      else $error("result out of range");

endmodule

bind perspective_correct_vertex_lerp_unit pcvl_checker u_pcvl_checker (.*);

`default_nettype wire
